FILE: sv/table_driven_token_lexer_top_macros.svh
// Assertion helpers used by the lexer output queue.
`ifndef TABLE_DRIVEN_TOKEN_LEXER_TOP_MACROS_SVH
`define TABLE_DRIVEN_TOKEN_LEXER_TOP_MACROS_SVH

// same-cycle implication
`define TDL_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tdl assertion failed");

// next-cycle implication
`define TDL_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tdl assertion failed");

`endif

FILE: sv/tdl_pkg.sv
`timescale 1ns / 1ps

package tdl_pkg;

    localparam int MANTISSA_BITS = 48;
    localparam int LENGTH_BITS   = 16;
    localparam int CP_W          = 21;
    localparam int KIND_W        = 5;
    localparam int FRAC_W        = 5;

    localparam int S_TDATA_W = ((CP_W + 7) / 8) * 8;
    localparam int M_DATA_W  = CP_W + MANTISSA_BITS + FRAC_W + 1 + LENGTH_BITS;
    localparam int M_TDATA_W = ((M_DATA_W + 7) / 8) * 8;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // result kinds
    localparam logic [KIND_W-1:0] K_ERROR   = 5'd0;
    localparam logic [KIND_W-1:0] K_EOF     = 5'd1;
    localparam logic [KIND_W-1:0] K_PLUS    = 5'd2;
    localparam logic [KIND_W-1:0] K_COLON   = 5'd3;
    localparam logic [KIND_W-1:0] K_COMMA   = 5'd4;
    localparam logic [KIND_W-1:0] K_MINUS   = 5'd5;
    localparam logic [KIND_W-1:0] K_PERCENT = 5'd6;
    localparam logic [KIND_W-1:0] K_STAR    = 5'd7;
    localparam logic [KIND_W-1:0] K_BAR     = 5'd8;
    localparam logic [KIND_W-1:0] K_QUERY   = 5'd9;
    localparam logic [KIND_W-1:0] K_SEMI    = 5'd10;
    localparam logic [KIND_W-1:0] K_DCOLON  = 5'd11;
    localparam logic [KIND_W-1:0] K_LBRACK  = 5'd12;
    localparam logic [KIND_W-1:0] K_RBRACK  = 5'd13;
    localparam logic [KIND_W-1:0] K_LPAREN  = 5'd14;
    localparam logic [KIND_W-1:0] K_RPAREN  = 5'd15;
    localparam logic [KIND_W-1:0] K_OPTIONS = 5'd16;
    localparam logic [KIND_W-1:0] K_REJECT  = 5'd17;
    localparam logic [KIND_W-1:0] K_NUMBER  = 5'd18;
    localparam logic [KIND_W-1:0] K_CHAR    = 5'd19;
    localparam logic [KIND_W-1:0] K_STRCHAR = 5'd20;
    localparam logic [KIND_W-1:0] K_STREND  = 5'd21;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [CP_W-1:0]          char_value;
        logic [MANTISSA_BITS-1:0] mantissa;
        logic [FRAC_W-1:0]        fraction_digits;
        logic                     number_overflow;
        logic [LENGTH_BITS-1:0]   string_length;
        logic                     last;
    } result_t;

    // up to two results from one character, r0 first
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

FILE: sv/tdl_lex_core.sv
`timescale 1ns / 1ps

module tdl_lex_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic [tdl_pkg::CP_W-1:0]  cp,
    output tdl_pkg::push_t            push
);

    localparam int STATE_W = 6;
    localparam int MB      = tdl_pkg::MANTISSA_BITS;
    localparam int LB      = tdl_pkg::LENGTH_BITS;
    localparam int CW      = tdl_pkg::CP_W;
    localparam int FW      = tdl_pkg::FRAC_W;
    localparam int WIDE_W  = MB + 4;

    localparam logic [STATE_W-1:0] ST_START    = 6'd0;
    localparam logic [STATE_W-1:0] ST_COMMENT  = 6'd1;
    localparam logic [STATE_W-1:0] ST_SYM_LO   = 6'd2;
    localparam logic [STATE_W-1:0] ST_SYM_HI   = 6'd15;
    localparam logic [STATE_W-1:0] ST_KW_O     = 6'd16;
    localparam logic [STATE_W-1:0] ST_KW_R     = 6'd23;
    localparam logic [STATE_W-1:0] ST_NUM      = 6'd29;
    localparam logic [STATE_W-1:0] ST_FRAC     = 6'd30;
    localparam logic [STATE_W-1:0] ST_CH_OPEN  = 6'd31;
    localparam logic [STATE_W-1:0] ST_CH_ESC   = 6'd32;
    localparam logic [STATE_W-1:0] ST_CH_HELD  = 6'd33;
    localparam logic [STATE_W-1:0] ST_CH_DONE  = 6'd34;
    localparam logic [STATE_W-1:0] ST_STR      = 6'd35;
    localparam logic [STATE_W-1:0] ST_STR_ESC  = 6'd36;
    localparam logic [STATE_W-1:0] ST_STR_DONE = 6'd37;

    localparam logic [2:0] KW_O_LEN = 3'd6;
    localparam logic [2:0] KW_R_LEN = 3'd5;

    localparam logic [6:0] CH_TAB    = 7'h09;
    localparam logic [6:0] CH_LF     = 7'h0A;
    localparam logic [6:0] CH_CR     = 7'h0D;
    localparam logic [6:0] CH_SPACE  = 7'h20;
    localparam logic [6:0] CH_DQUOTE = 7'h22;
    localparam logic [6:0] CH_HASH   = 7'h23;
    localparam logic [6:0] CH_QUOTE  = 7'h27;
    localparam logic [6:0] CH_DOT    = 7'h2E;
    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_NINE   = 7'h39;
    localparam logic [6:0] CH_COLON  = 7'h3A;
    localparam logic [6:0] CH_BSLASH = 7'h5C;
    localparam logic [6:0] CH_LOW_O  = 7'h6F;
    localparam logic [6:0] CH_LOW_R  = 7'h72;

    localparam logic [MB-1:0] MANT_MAX = {MB{1'b1}};
    localparam logic [LB-1:0] LEN_MAX  = {LB{1'b1}};
    localparam logic [FW-1:0] FRAC_MAX = {FW{1'b1}};

    function automatic logic [tdl_pkg::KIND_W-1:0] symbol_kind(input logic [6:0] c);
        logic [tdl_pkg::KIND_W-1:0] k;
        k = tdl_pkg::K_ERROR;
        unique case (c)
            7'h2B:   k = tdl_pkg::K_PLUS;
            7'h3A:   k = tdl_pkg::K_COLON;
            7'h2C:   k = tdl_pkg::K_COMMA;
            7'h2D:   k = tdl_pkg::K_MINUS;
            7'h25:   k = tdl_pkg::K_PERCENT;
            7'h2A:   k = tdl_pkg::K_STAR;
            7'h7C:   k = tdl_pkg::K_BAR;
            7'h3F:   k = tdl_pkg::K_QUERY;
            7'h3B:   k = tdl_pkg::K_SEMI;
            7'h5B:   k = tdl_pkg::K_LBRACK;
            7'h5D:   k = tdl_pkg::K_RBRACK;
            7'h28:   k = tdl_pkg::K_LPAREN;
            7'h29:   k = tdl_pkg::K_RPAREN;
            default: k = tdl_pkg::K_ERROR;
        endcase
        return k;
    endfunction

    // remaining letters of "options" after the 'o'
    function automatic logic [6:0] options_char(input logic [2:0] i);
        logic [6:0] ch;
        unique case (i)
            3'd0:    ch = 7'h70;
            3'd1:    ch = 7'h74;
            3'd2:    ch = 7'h69;
            3'd3:    ch = 7'h6F;
            3'd4:    ch = 7'h6E;
            3'd5:    ch = 7'h73;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    // remaining letters of "reject" after the 'r'
    function automatic logic [6:0] reject_char(input logic [2:0] i);
        logic [6:0] ch;
        unique case (i)
            3'd0:    ch = 7'h65;
            3'd1:    ch = 7'h6A;
            3'd2:    ch = 7'h65;
            3'd3:    ch = 7'h63;
            3'd4:    ch = 7'h74;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    logic [STATE_W-1:0] st_reg,   st_next;
    logic [MB-1:0]      acc_reg,  acc_next;
    logic [FW-1:0]      frac_reg, frac_next;
    logic               ovf_reg,  ovf_next;
    logic [CW-1:0]      held_reg, held_next;
    logic [LB-1:0]      scnt_reg, scnt_next;

    // column: anything above 127 never matches an ASCII character
    logic       hi;
    logic [6:0] lo;
    logic       is_nul, is_digit, is_dot, is_bslash, is_dquote, is_quote, is_lf;
    logic [3:0] digit;
    logic [WIDE_W-1:0] wide;
    logic       mant_ovf;
    logic       esc_v;
    logic [CW-1:0] esc_val;
    logic [2:0] kwo_i, kwr_i;
    logic [STATE_W-1:0] kwo_off, kwr_off;

    assign hi        = |cp[CW-1:7];
    assign lo        = cp[6:0];
    assign is_nul    = !hi && lo == 7'h00;
    assign is_digit  = !hi && lo >= CH_ZERO && lo <= CH_NINE;
    assign is_dot    = !hi && lo == CH_DOT;
    assign is_bslash = !hi && lo == CH_BSLASH;
    assign is_dquote = !hi && lo == CH_DQUOTE;
    assign is_quote  = !hi && lo == CH_QUOTE;
    assign is_lf     = !hi && lo == CH_LF;
    assign digit     = lo[3:0];

    // acc*10 + d, carried with four extra bits; any carry out means overflow (the integer part saturates)
    assign wide     = ({4'b0000, acc_reg} << 3) + ({4'b0000, acc_reg} << 1)
                    + WIDE_W'(digit);
    assign mant_ovf = |wide[WIDE_W-1:MB];

    assign kwo_off = st_reg - ST_KW_O;
    assign kwr_off = st_reg - ST_KW_R;
    assign kwo_i   = kwo_off[2:0];
    assign kwr_i   = kwr_off[2:0];

    always_comb begin
        esc_v   = !hi;
        esc_val = '0;
        unique case (lo)
            CH_BSLASH: esc_val = CW'(CH_BSLASH);
            CH_DQUOTE: esc_val = CW'(CH_DQUOTE);
            7'h72:     esc_val = CW'(CH_CR);
            7'h74:     esc_val = CW'(CH_TAB);
            7'h6E:     esc_val = CW'(CH_LF);
            CH_ZERO:   esc_val = '0;
            default:   esc_v   = 1'b0;
        endcase
    end

    tdl_pkg::result_t tok, tok2;
    logic    tok_v, tok2_v, do_start;
    logic [tdl_pkg::KIND_W-1:0] sk;

    always_comb begin
        st_next   = st_reg;
        acc_next  = acc_reg;
        frac_next = frac_reg;
        ovf_next  = ovf_reg;
        held_next = held_reg;
        scnt_next = scnt_reg;
        tok       = '0;
        tok2      = '0;
        tok_v     = 1'b0;
        tok2_v    = 1'b0;
        do_start  = 1'b0;
        sk        = symbol_kind(lo);

        priority if (st_reg >= ST_SYM_LO && st_reg <= ST_SYM_HI) begin
            if (st_reg == STATE_W'(tdl_pkg::K_COLON) && !hi && lo == CH_COLON) begin
                st_next = STATE_W'(tdl_pkg::K_DCOLON);
            end else begin
                tok_v    = 1'b1;
                tok.kind = st_reg[tdl_pkg::KIND_W-1:0];
                do_start = 1'b1;
            end
        end else if (st_reg == ST_COMMENT) begin
            if (is_nul) begin
                st_next  = ST_START;
                tok_v    = 1'b1;
                tok.kind = tdl_pkg::K_EOF;
            end else if (is_lf) begin
                st_next = ST_START;
            end
        end else if (st_reg >= ST_KW_O && st_reg < ST_KW_R) begin
            if (kwo_i == KW_O_LEN) begin
                tok_v    = 1'b1;
                tok.kind = tdl_pkg::K_OPTIONS;
                do_start = 1'b1;
            end else if (!hi && lo == options_char(kwo_i)) begin
                st_next = st_reg + 1'b1;
            end else begin
                st_next  = ST_START;
                tok_v    = 1'b1;
                tok.kind = tdl_pkg::K_ERROR;
            end
        end else if (st_reg >= ST_KW_R && st_reg < ST_NUM) begin
            if (kwr_i == KW_R_LEN) begin
                tok_v    = 1'b1;
                tok.kind = tdl_pkg::K_REJECT;
                do_start = 1'b1;
            end else if (!hi && lo == reject_char(kwr_i)) begin
                st_next = st_reg + 1'b1;
            end else begin
                st_next  = ST_START;
                tok_v    = 1'b1;
                tok.kind = tdl_pkg::K_ERROR;
            end
        end else if (st_reg == ST_NUM || st_reg == ST_FRAC) begin
            if (is_digit) begin
                if (st_reg == ST_FRAC && frac_reg == FRAC_MAX) begin
                    ovf_next = 1'b1;
                end else if (mant_ovf) begin
                    ovf_next = 1'b1;
                    if (st_reg == ST_NUM) begin
                        acc_next = MANT_MAX;
                    end
                end else begin
                    acc_next = wide[MB-1:0];
                    if (st_reg == ST_FRAC) begin
                        frac_next = frac_reg + 1'b1;
                    end
                end
            end else if (st_reg == ST_NUM && is_dot) begin
                st_next = ST_FRAC;
            end else begin
                tok_v               = 1'b1;
                tok.kind            = tdl_pkg::K_NUMBER;
                tok.mantissa        = acc_reg;
                tok.fraction_digits = frac_reg;
                tok.number_overflow = ovf_reg;
                do_start            = 1'b1;
            end
        end else if (st_reg == ST_CH_OPEN) begin
            if (is_nul) begin
                st_next  = ST_START;
                tok_v    = 1'b1;
                tok.kind = tdl_pkg::K_ERROR;
            end else if (is_bslash) begin
                st_next = ST_CH_ESC;
            end else begin
                held_next = cp;
                st_next   = ST_CH_HELD;
            end
        end else if (st_reg == ST_CH_ESC) begin
            if (!esc_v) begin
                st_next  = ST_START;
                tok_v    = 1'b1;
                tok.kind = tdl_pkg::K_ERROR;
            end else begin
                held_next = esc_val;
                st_next   = ST_CH_HELD;
            end
        end else if (st_reg == ST_CH_HELD) begin
            if (is_quote) begin
                st_next = ST_CH_DONE;
            end else begin
                st_next  = ST_START;
                tok_v    = 1'b1;
                tok.kind = tdl_pkg::K_ERROR;
            end
        end else if (st_reg == ST_CH_DONE) begin
            tok_v          = 1'b1;
            tok.kind       = tdl_pkg::K_CHAR;
            tok.char_value = held_reg;
            do_start       = 1'b1;
        end else if (st_reg == ST_STR || st_reg == ST_STR_ESC) begin
            if (st_reg == ST_STR && is_nul) begin
                st_next  = ST_START;
                tok_v    = 1'b1;
                tok.kind = tdl_pkg::K_ERROR;
            end else if (st_reg == ST_STR && is_bslash) begin
                st_next = ST_STR_ESC;
            end else if (st_reg == ST_STR && is_dquote) begin
                st_next = ST_STR_DONE;
            end else if (st_reg == ST_STR_ESC && !esc_v) begin
                st_next  = ST_START;
                tok_v    = 1'b1;
                tok.kind = tdl_pkg::K_ERROR;
            end else begin
                st_next        = ST_STR;
                tok_v          = 1'b1;
                tok.kind       = tdl_pkg::K_STRCHAR;
                tok.char_value = (st_reg == ST_STR) ? cp : esc_val;
                if (scnt_reg != LEN_MAX) begin
                    scnt_next = scnt_reg + 1'b1;
                end
            end
        end else if (st_reg == ST_STR_DONE) begin
            tok_v             = 1'b1;
            tok.kind          = tdl_pkg::K_STREND;
            tok.string_length = scnt_reg;
            do_start          = 1'b1;
        end else begin
            // start, and any code that is never entered
            do_start = 1'b1;
        end

        // the ending character is re-run from the start state
        if (do_start) begin
            st_next = ST_START;
            priority if (is_nul) begin
                tok2_v    = 1'b1;
                tok2.kind = tdl_pkg::K_EOF;
            end else if (!hi && (lo == CH_SPACE || lo == CH_TAB || lo == CH_CR
                                 || lo == CH_LF)) begin
                st_next = ST_START;
            end else if (!hi && lo == CH_HASH) begin
                st_next = ST_COMMENT;
            end else if (!hi && sk != tdl_pkg::K_ERROR) begin
                st_next = STATE_W'(sk);
            end else if (!hi && lo == CH_LOW_O) begin
                st_next = ST_KW_O;
            end else if (!hi && lo == CH_LOW_R) begin
                st_next = ST_KW_R;
            end else if (is_digit) begin
                acc_next  = MB'(digit);
                frac_next = '0;
                ovf_next  = 1'b0;
                st_next   = ST_NUM;
            end else if (is_quote) begin
                held_next = '0;
                st_next   = ST_CH_OPEN;
            end else if (is_dquote) begin
                scnt_next = '0;
                st_next   = ST_STR;
            end else begin
                tok2_v    = 1'b1;
                tok2.kind = tdl_pkg::K_ERROR;
            end
        end
    end

    always_comb begin
        push = '0;
        if (tok_v) begin
            push.v0      = adv;
            push.v1      = adv && tok2_v;
            push.r0      = tok;
            push.r0.last = !tok2_v;
            push.r1      = tok2;
            push.r1.last = 1'b1;
        end else begin
            push.v0      = adv && tok2_v;
            push.r0      = tok2;
            push.r0.last = 1'b1;
            push.r1      = tok2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_START;
            acc_reg  <= '0;
            frac_reg <= '0;
            ovf_reg  <= 1'b0;
            held_reg <= '0;
            scnt_reg <= '0;
        end else if (adv) begin
            st_reg   <= st_next;
            acc_reg  <= acc_next;
            frac_reg <= frac_next;
            ovf_reg  <= ovf_next;
            held_reg <= held_next;
            scnt_reg <= scnt_next;
        end
    end

endmodule

FILE: sv/tdl_out_queue.sv
`timescale 1ns / 1ps
`include "table_driven_token_lexer_top_macros.svh"

module tdl_out_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  tdl_pkg::push_t   push,
    output logic             room,
    output logic             m_tvalid,
    input  logic             m_tready,
    output tdl_pkg::result_t m_out
);

    localparam int PW = tdl_pkg::Q_PTR_W;
    localparam int CW = PW + 1;

    tdl_pkg::result_t mem [tdl_pkg::Q_DEPTH];

    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next, wr_inc;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    n_push;
    logic          pop;

    assign pop      = m_tvalid && m_tready;
    assign n_push   = {1'b0, push.v0} + {1'b0, push.v1};
    assign wr_inc   = wr_reg + PW'(1);
    assign wr_next  = wr_reg + PW'(n_push);
    assign rd_next  = rd_reg + PW'(pop);
    assign cnt_next = cnt_reg + CW'(n_push) - CW'(pop);

    // two free slots needed, as one character may give two beats
    assign room     = cnt_reg <= CW'(tdl_pkg::Q_DEPTH - 2);
    assign m_tvalid = cnt_reg != '0;
    assign m_out    = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push.v0) begin
            mem[wr_reg] <= push.r0;
        end
        if (push.v1) begin
            mem[wr_inc] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    `TDL_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CW'(tdl_pkg::Q_DEPTH))
    `TDL_ASSERT_IMP(a_push_room, aclk, aresetn, push.v0, cnt_reg <= CW'(tdl_pkg::Q_DEPTH - 2))
    `TDL_ASSERT_IMP(a_push_order, aclk, aresetn, push.v1, push.v0 && !push.r0.last)
    `TDL_ASSERT_IMP(a_last_single, aclk, aresetn, push.v0 && !push.v1, push.r0.last)
    `TDL_ASSERT_NXT(a_drain, aclk, aresetn, pop && !push.v0, cnt_reg == $past(cnt_reg) - 1'b1)

endmodule

FILE: sv/table_driven_token_lexer_top.sv
`timescale 1ns / 1ps
// Channel  Dir  tdata                                  tuser  tlast
// s_       in   code_point                             -      -
// m_       out  char_value, mantissa, fraction_digits, kind   last
//               number_overflow, string_length
//
// One character a cycle while the queue has room: input register, then the
// transition logic (state compare, mantissa x10 plus digit) writes its zero,
// one or two beats into a four-entry output queue. The output drains one
// beat a cycle while m_tready is high, so characters that end one token and
// start a failing one or end the input (two beats) can fill the queue and
// stall the input. Reset clears the lexer to its start state and empties the
// queue; s_tready drops while a character waits in the input register and
// the queue holds more than two beats.

module table_driven_token_lexer_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tdl_pkg::S_TDATA_W-1:0]    s_tdata,   // code_point
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // char_value, mantissa, fraction_digits, number_overflow, string_length
    output logic [tdl_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [tdl_pkg::KIND_W-1:0]       m_tuser,   // kind
    output logic                             m_tlast    // last
);

    logic                     in_valid_reg;
    logic [tdl_pkg::CP_W-1:0] in_cp_reg;
    logic                     room, adv;
    tdl_pkg::push_t           push;
    tdl_pkg::result_t         res;

    assign adv      = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cp_reg <= s_tdata[tdl_pkg::CP_W-1:0];
        end
    end

    tdl_lex_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .cp      (in_cp_reg),
        .push    (push)
    );

    tdl_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_out    (res)
    );

    assign m_tdata = tdl_pkg::M_TDATA_W'({res.string_length, res.number_overflow,
                                          res.fraction_digits, res.mantissa,
                                          res.char_value});
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule
